// File: hw/rtl/seeded_prng_range_draw_assert.svh
// Assertion macros for the seeded range-draw generator checker.
// Depends on nothing; the clock and reset are the block's i_clk and i_rst_n.
`ifndef SEEDED_PRNG_RANGE_DRAW_ASSERT_SVH
`define SEEDED_PRNG_RANGE_DRAW_ASSERT_SVH

// Property checked on every clock edge outside of reset.
`define SRD_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define SRD_ASSERT_ALL(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hw/rtl/srd_pkg.sv
// Shared constants for the seeded range-draw generator.
// No dependencies; used by the top level and the port checker.
`timescale 1ns / 1ps

package srd_pkg;

    localparam int SEED_W    = 64;
    localparam int BOUND_W   = 32;
    localparam int SPAN_W    = BOUND_W + 1;
    localparam int HALF_W    = SEED_W / 2;
    localparam int WORDS     = 4;
    localparam int WORD_IX_W = $clog2(WORDS);
    localparam int BIT_CNT_W = $clog2(SEED_W);

    // Seed mixer constants
    localparam logic [SEED_W-1:0] MIX_GOLDEN = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [SEED_W-1:0] MIX_C1     = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [SEED_W-1:0] MIX_C2     = 64'h94d0_49bb_1331_11eb;
    localparam int MIX_SH1 = 30;
    localparam int MIX_SH2 = 27;
    localparam int MIX_SH3 = 31;

    // Generator step constants
    localparam int GEN_T_SH  = 17;
    localparam int GEN_S3_RL = 45;
    localparam int GEN_OUT_RL = 7;

endpackage

// File: hw/rtl/seeded_prng_range_draw.sv
// Channel   Handshake           Payload
// input     i_valid / o_ready   i_action, i_seed, i_range_from, i_range_to
// output    o_valid / i_ready   o_value (one per draw, none per reseed)
//
// Reseed: four chained mixes, each an add, two 64-bit products on the shared 32x32
//   multiplier, and a store.
// Draw: the 64-by-33-bit remainder takes one bit per cycle.
// Draw with equal bounds: o_valid in the cycle after the transfer, state untouched.
// One item at a time; o_ready is low until a reseed ends or the result is taken.
//   Synchronous reset clears the generator words to zero.
// Top level of the seeded range-draw generator; one shared multiplier and a
// bit-serial remainder unit under a small sequencer. Depends on srd_pkg.
`timescale 1ns / 1ps

module seeded_prng_range_draw (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_action,
    input  logic        [srd_pkg::SEED_W-1:0]     i_seed,
    input  logic signed [srd_pkg::BOUND_W-1:0]    i_range_from,
    input  logic signed [srd_pkg::BOUND_W-1:0]    i_range_to,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [srd_pkg::BOUND_W-1:0]    o_value
);
    import srd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_HADD, S_HMUL, S_HFIN, S_GEN0, S_GEN1, S_MOD, S_FIN, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_LL, PH_LH, PH_HL, PH_SUM
    } t_phase;

    t_state                     r_state;
    t_phase                     r_phase;
    logic                       r_msel;
    logic [WORD_IX_W-1:0]       r_widx;
    logic [BIT_CNT_W-1:0]       r_cnt;
    logic [SEED_W-1:0]          r_s [WORDS];
    logic [SEED_W-1:0]          r_x;
    logic [SEED_W-1:0]          r_acc;
    logic [SEED_W-1:0]          r_prod;
    logic signed [BOUND_W-1:0]  r_lo;
    logic signed [BOUND_W-1:0]  r_hi;
    logic                       r_dir;
    logic [SPAN_W-1:0]          r_span;
    logic [SPAN_W-1:0]          r_rem;
    logic                       r_valid;
    logic [BOUND_W-1:0]         r_value;

    logic [SEED_W-1:0]  mul_a;
    logic [SEED_W-1:0]  mul_b;
    logic [HALF_W-1:0]  op_a;
    logic [HALF_W-1:0]  op_b;
    logic [SEED_W-1:0]  mul_p;
    logic [SEED_W-1:0]  hword;
    logic [SEED_W-1:0]  s1x5;
    logic [SEED_W-1:0]  rot7;
    logic [SEED_W-1:0]  x9;
    logic [SEED_W-1:0]  s2a;
    logic [SEED_W-1:0]  s3a;
    logic [SEED_W-1:0]  n_s0;
    logic [SEED_W-1:0]  n_s1;
    logic [SEED_W-1:0]  n_s2;
    logic [SEED_W-1:0]  n_s3;
    logic [SPAN_W-1:0]  lo_ext;
    logic [SPAN_W-1:0]  hi_ext;
    logic [SPAN_W-1:0]  gap;
    logic [SPAN_W-1:0]  n_span;
    logic [SPAN_W:0]    mod_sh;
    logic               mod_ge;
    logic [SPAN_W:0]    mod_nx;
    logic [BOUND_W-1:0] n_value;

    // Shared multiplier: one 32x32 partial product of the low 64-bit product
    assign mul_a = r_msel ? (r_x ^ (r_x >> MIX_SH2)) : (r_x ^ (r_x >> MIX_SH1));
    assign mul_b = r_msel ? MIX_C2 : MIX_C1;

    always_comb begin
        case (r_phase)
            PH_LL: begin
                op_a = mul_a[HALF_W-1:0];
                op_b = mul_b[HALF_W-1:0];
            end
            PH_LH: begin
                op_a = mul_a[HALF_W-1:0];
                op_b = mul_b[SEED_W-1:HALF_W];
            end
            default: begin
                op_a = mul_a[SEED_W-1:HALF_W];
                op_b = mul_b[HALF_W-1:0];
            end
        endcase
    end

    assign mul_p = SEED_W'(op_a) * SEED_W'(op_b);
    assign hword = r_x ^ (r_x >> MIX_SH3);

    // Generator step, all from the old words
    assign s2a  = r_s[2] ^ r_s[0];
    assign s3a  = r_s[3] ^ r_s[1];
    assign n_s0 = r_s[0] ^ s3a;
    assign n_s1 = r_s[1] ^ s2a;
    assign n_s2 = s2a ^ (r_s[1] << GEN_T_SH);
    assign n_s3 = (s3a << GEN_S3_RL) | (s3a >> (SEED_W - GEN_S3_RL));

    // Scrambled output: rotl(s1 * 5, 7) * 9, s1 * 5 in S_GEN0 and the rest in S_GEN1
    assign s1x5 = r_s[1] + (r_s[1] << 2);
    assign rot7 = (r_x << GEN_OUT_RL) | (r_x >> (SEED_W - GEN_OUT_RL));
    assign x9   = rot7 + (rot7 << 3);

    assign lo_ext = {r_lo[BOUND_W-1], r_lo};
    assign hi_ext = {r_hi[BOUND_W-1], r_hi};
    assign gap    = r_dir ? (lo_ext - hi_ext) : (hi_ext - lo_ext);
    assign n_span = gap + SPAN_W'(1);

    // Restoring remainder, one dividend bit per cycle
    assign mod_sh = {r_rem, r_x[SEED_W-1]};
    assign mod_ge = mod_sh >= {1'b0, r_span};
    assign mod_nx = mod_ge ? (mod_sh - {1'b0, r_span}) : mod_sh;

    assign n_value = r_dir ? (r_lo - r_rem[BOUND_W-1:0]) : (r_lo + r_rem[BOUND_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_LL;
            r_msel  <= 1'b0;
            r_widx  <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
            for (int i = 0; i < WORDS; i++) begin
                r_s[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (!i_action) begin
                            r_x     <= i_seed;
                            r_widx  <= '0;
                            r_state <= S_HADD;
                        end else begin
                            r_lo  <= i_range_from;
                            r_hi  <= i_range_to;
                            r_dir <= i_range_from > i_range_to;
                            if (i_range_from == i_range_to) begin
                                // equal bounds: answer at once, leave the words alone
                                r_value <= i_range_from;
                                r_valid <= 1'b1;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_GEN0;
                            end
                        end
                    end
                end
                S_HADD: begin
                    r_x     <= r_x + MIX_GOLDEN;
                    r_msel  <= 1'b0;
                    r_phase <= PH_LL;
                    r_state <= S_HMUL;
                end
                S_HMUL: begin
                    r_prod  <= mul_p;
                    r_phase <= t_phase'(r_phase + 2'd1);
                    case (r_phase)
                        PH_LH: begin
                            r_acc <= r_prod;
                        end
                        PH_HL: begin
                            r_acc[SEED_W-1:HALF_W] <= r_acc[SEED_W-1:HALF_W]
                                                      + r_prod[HALF_W-1:0];
                        end
                        PH_SUM: begin
                            r_x <= {r_acc[SEED_W-1:HALF_W] + r_prod[HALF_W-1:0],
                                    r_acc[HALF_W-1:0]};
                            if (r_msel) begin
                                r_state <= S_HFIN;
                            end else begin
                                r_msel <= 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_HFIN: begin
                    // store this word and chain it into the next mix
                    r_s[r_widx] <= hword;
                    r_x         <= hword;
                    r_widx      <= r_widx + WORD_IX_W'(1);
                    if (r_widx == WORD_IX_W'(WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_HADD;
                    end
                end
                S_GEN0: begin
                    r_x     <= s1x5;
                    r_s[0]  <= n_s0;
                    r_s[1]  <= n_s1;
                    r_s[2]  <= n_s2;
                    r_s[3]  <= n_s3;
                    r_state <= S_GEN1;
                end
                S_GEN1: begin
                    r_x     <= x9;
                    r_span  <= n_span;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_rem <= mod_nx[SPAN_W-1:0];
                    r_x   <= r_x << 1;
                    r_cnt <= r_cnt + BIT_CNT_W'(1);
                    if (r_cnt == BIT_CNT_W'(SEED_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_value <= n_value;
                    r_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold the result until the transfer
                    if (i_ready) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

// File: hw/rtl/srd_checker.sv
// Port-level checker for the seeded range-draw generator, bound to the top level.
// Depends on srd_pkg and seeded_prng_range_draw_assert.svh.
`timescale 1ns / 1ps
`include "seeded_prng_range_draw_assert.svh"

module srd_port_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_valid,
    input logic                                  o_ready,
    input logic                                  i_action,
    input logic signed [srd_pkg::BOUND_W-1:0]    i_range_from,
    input logic signed [srd_pkg::BOUND_W-1:0]    i_range_to,
    input logic                                  o_valid,
    input logic                                  i_ready,
    input logic signed [srd_pkg::BOUND_W-1:0]    o_value
);
    import srd_pkg::*;

    logic in_xfer;
    logic out_stall;
    logic eq_xfer;

    assign in_xfer   = i_valid && o_ready;
    assign out_stall = o_valid && !i_ready;
    assign eq_xfer   = in_xfer && i_action && (i_range_from == i_range_to);

    `SRD_ASSERT_RUN(a_out_hold, out_stall |=> o_valid && $stable(o_value), "result moved")
    `SRD_ASSERT_RUN(a_busy_with_result, o_valid |-> !o_ready, "input taken while a result waits")
    `SRD_ASSERT_RUN(a_reseed_silent, in_xfer && !i_action |=> !o_valid, "reseed gave a result")
    `SRD_ASSERT_RUN(a_eq_bound, eq_xfer |=> o_valid && o_value == $past(i_range_from), "bad bound")
    `SRD_ASSERT_ALL(a_reset_idle, !i_rst_n |=> !o_valid && o_ready, "not idle after reset")

endmodule

bind seeded_prng_range_draw srd_port_checker u_srd_checker (.*);

// File: verif/srd_tb_pkg.sv
// Request codes shared by the range-draw testbench top and its checker.
// Depends on nothing.
`timescale 1ns / 1ps

package srd_tb_pkg;

    typedef enum logic {
        ACT_RESEED = 1'b0,
        ACT_DRAW   = 1'b1
    } t_action;

endpackage

// File: verif/srd_checker.sv
// Checker for the seeded range-draw generator: tracks the xoshiro256** state,
// predicts each draw and compares it with the output transfers.
// Depends on srd_pkg and srd_tb_pkg.
`timescale 1ns / 1ps

module srd_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic                               i_action,
    input  logic        [srd_pkg::SEED_W-1:0]  i_seed,
    input  logic signed [srd_pkg::BOUND_W-1:0] i_range_from,
    input  logic signed [srd_pkg::BOUND_W-1:0] i_range_to,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic signed [srd_pkg::BOUND_W-1:0] i_value,
    output int                                 o_errors,
    output int                                 o_pending
);
    import srd_pkg::*;
    import srd_tb_pkg::*;

    typedef struct {
        logic signed [BOUND_W-1:0] from_b;
        logic signed [BOUND_W-1:0] to_b;
        logic signed [BOUND_W-1:0] value;
    } t_draw;

    logic [SEED_W-1:0] gen_state [WORDS];
    t_draw             draws_waiting [$];
    int                mismatch_cnt;

    initial begin
        mismatch_cnt = 0;
        o_errors     = 0;
        o_pending    = 0;
        foreach (gen_state[k]) gen_state[k] = '0;
    end

    function automatic logic [63:0] splitmix_hash(input logic [63:0] x);
        logic [63:0] z;
        z = x + 64'h9e37_79b9_7f4a_7c15;
        z = (z ^ (z >> 30)) * 64'hbf58_476d_1ce4_e5b9;
        z = (z ^ (z >> 27)) * 64'h94d0_49bb_1331_11eb;
        return z ^ (z >> 31);
    endfunction

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int amt);
        return (v << amt) | (v >> (64 - amt));
    endfunction

    // Return the next generator output and advance the state.
    function automatic logic [63:0] xoshiro_next();
        logic [63:0] result;
        logic [63:0] t;
        result = rotl64(gen_state[1] * 64'd5, 7) * 64'd9;
        t = gen_state[1] << 17;
        gen_state[2] ^= gen_state[0];
        gen_state[3] ^= gen_state[1];
        gen_state[1] ^= gen_state[2];
        gen_state[0] ^= gen_state[3];
        gen_state[2] ^= t;
        gen_state[3] = rotl64(gen_state[3], 45);
        return result;
    endfunction

    function automatic logic [BOUND_W-1:0] draw_in_range(
        input logic signed [BOUND_W-1:0] a,
        input logic signed [BOUND_W-1:0] b
    );
        longint      lo;
        longint      hi;
        logic [63:0] span;
        logic [63:0] r;
        lo = a;
        hi = b;
        // Equal bounds leave the generator untouched.
        if (lo == hi) return a;
        if (lo < hi) span = 64'(hi - lo) + 64'd1;
        else         span = 64'(lo - hi) + 64'd1;
        r = xoshiro_next() % span;
        if (lo < hi) return a + r[BOUND_W-1:0];
        else         return a - r[BOUND_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_draw d;
        if (!i_rst_n) begin
            foreach (gen_state[k]) gen_state[k] = '0;
            draws_waiting.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (draws_waiting.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("[%0t] result %0d with no draw outstanding", $time, i_value);
                end else begin
                    d = draws_waiting.pop_front();
                    if (i_value !== d.value) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("[%0t] draw %0d..%0d: expected %0d, got %0d",
                                     $time, d.from_b, d.to_b, d.value, i_value);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_action == ACT_RESEED) begin
                    gen_state[0] = splitmix_hash(i_seed);
                    for (int k = 1; k < WORDS; k++)
                        gen_state[k] = splitmix_hash(gen_state[k-1]);
                end else begin
                    d.from_b = i_range_from;
                    d.to_b   = i_range_to;
                    d.value  = draw_in_range(i_range_from, i_range_to);
                    draws_waiting.push_back(d);
                end
            end
        end
        o_errors  <= mismatch_cnt;
        o_pending <= draws_waiting.size();
    end

endmodule

// File: verif/testbench.sv
// Stimulus and verdict for the seeded range-draw generator: directed corner
// requests, then random reseeds and draws under varying idle and stall phases.
// Depends on srd_pkg, srd_tb_pkg, srd_checker and the block itself.
`timescale 1ns / 1ps

module testbench;
    import srd_pkg::*;
    import srd_tb_pkg::*;

    localparam logic signed [BOUND_W-1:0] B_MIN = 32'sh8000_0000;
    localparam logic signed [BOUND_W-1:0] B_MAX = 32'sh7fff_ffff;
    localparam int RANDOM_ITEMS = 750;
    localparam int PHASE_ITEMS  = 94;
    localparam int TAIL_CYCLES  = 100;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic                      i_action = 1'b0;
    logic        [SEED_W-1:0]  i_seed = '0;
    logic signed [BOUND_W-1:0] i_range_from = '0;
    logic signed [BOUND_W-1:0] i_range_to = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic signed [BOUND_W-1:0] o_value;

    int chk_errors;
    int chk_pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int idle_tab [4] = '{0, 72, 0, 33};
    int stall_tab [4] = '{0, 0, 72, 33};
    logic signed [BOUND_W-1:0] edge_vals [7] = '{B_MIN, B_MIN + 1, -1, 0, 1, B_MAX - 1, B_MAX};

    always #10 i_clk = ~i_clk;

    seeded_prng_range_draw i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_seed       (i_seed),
        .i_range_from (i_range_from),
        .i_range_to   (i_range_to),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_value      (o_value)
    );

    srd_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_action     (i_action),
        .i_seed       (i_seed),
        .i_range_from (i_range_from),
        .i_range_to   (i_range_to),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_value      (o_value),
        .o_errors     (chk_errors),
        .o_pending    (chk_pending)
    );

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Present one request and hold it until the transfer edge.
    task automatic send_item(input t_action act, input logic [SEED_W-1:0] seed,
                             input logic [BOUND_W-1:0] from_v,
                             input logic [BOUND_W-1:0] to_v);
        if ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        i_valid      <= 1'b1;
        i_action     <= act;
        i_seed       <= seed;
        i_range_from <= from_v;
        i_range_to   <= to_v;
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic logic [BOUND_W-1:0] pick_edge();
        return edge_vals[$urandom_range(0, 6)];
    endfunction

    task automatic random_item();
        int                 roll;
        logic [SEED_W-1:0]  seed;
        logic [BOUND_W-1:0] from_v;
        logic [BOUND_W-1:0] to_v;
        roll   = $urandom_range(0, 99);
        seed   = {$urandom, $urandom};
        from_v = $urandom;
        to_v   = $urandom;
        if (roll < 10) begin
            send_item(ACT_RESEED, seed, from_v, to_v);
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 25) begin
                to_v = from_v + 32'($urandom_range(0, 80)) - 32'd40;
            end else if (roll < 35) begin
                to_v = from_v;
            end else if (roll < 50) begin
                from_v = pick_edge();
                to_v   = ($urandom_range(0, 1) != 0) ? pick_edge() : $urandom;
            end else if (roll < 65) begin
                if ($urandom_range(0, 1) != 0) to_v = from_v + ($urandom >> $urandom_range(0, 31));
                else                           to_v = from_v - ($urandom >> $urandom_range(0, 31));
            end
            send_item(ACT_DRAW, seed, from_v, to_v);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Generator still all zero: draws return the first bound.
        send_item(ACT_DRAW, 64'h1234_5678_9abc_def0, 32'sd5, 32'sd100);
        send_item(ACT_DRAW, '0, -32'sd3, -32'sd90);
        send_item(ACT_DRAW, '0, 32'sd77, 32'sd77);
        // Seed zero hashes like any other; bounds on a reseed are ignored.
        send_item(ACT_RESEED, '0, B_MIN, B_MAX);
        send_item(ACT_DRAW, '1, B_MIN, B_MAX);
        send_item(ACT_DRAW, '0, B_MAX, B_MIN);
        send_item(ACT_DRAW, '0, B_MIN, B_MIN);
        send_item(ACT_DRAW, '0, B_MAX, B_MAX);
        send_item(ACT_DRAW, '0, 32'sd0, 32'sd1);
        send_item(ACT_DRAW, '0, 32'sd1, 32'sd0);
        send_item(ACT_RESEED, '1, 32'sd0, 32'sd0);
        send_item(ACT_DRAW, '0, -32'sd1, 32'sd0);
        send_item(ACT_DRAW, '0, B_MIN, B_MIN + 1);
        send_item(ACT_DRAW, '0, B_MAX - 1, B_MAX);
        send_item(ACT_DRAW, '0, B_MAX, -32'sd1);
        send_item(ACT_DRAW, '0, B_MIN, 32'sd0);
        send_item(ACT_RESEED, 64'h8000_0000_0000_0000, 32'sd9, 32'sd9);
        send_item(ACT_DRAW, 64'h5555_5555_5555_5555, 32'sd0, B_MAX);
        send_item(ACT_DRAW, 64'haaaa_aaaa_aaaa_aaaa, 32'sd0, B_MIN);
        send_item(ACT_RESEED, 64'h0000_0000_0000_0001, 32'sd0, 32'sd0);
        send_item(ACT_DRAW, '0, -32'sd1000, 32'sd1000);
        send_item(ACT_DRAW, '0, 32'sd1000, -32'sd1000);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_pct  = idle_tab[(n / PHASE_ITEMS) % 4];
            stall_pct = stall_tab[(n / PHASE_ITEMS) % 4];
            random_item();
        end
        i_valid <= 1'b0;
        @(posedge i_clk);

        while (chk_pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (chk_pending != 0)
            $display("%0d draws never returned a result", chk_pending);
        if (chk_errors == 0 && chk_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Abort a hung run.
    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
